// ===== sv/lgnc_pkg.sv =====
// ----------------------------------------------------------------------------
// lgnc_pkg: shared types for the life grid neighbor counter
// command and boundary codes, register indexes, item and result payloads
// ----------------------------------------------------------------------------
package lgnc_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // edge handling
  typedef enum logic [1:0] {
    MODE_CLASSIC = 2'd0,
    MODE_DONUT   = 2'd1,
    MODE_MIRROR  = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_ROWS     = 2'd0;
  localparam logic [1:0] REG_GRID_COLS     = 2'd1;
  localparam logic [1:0] REG_BOUNDARY_MODE = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int SIZE_W      = 7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_value;
  } item_t;

  typedef struct packed {
    logic       cell_alive;
    logic [3:0] neighbor_count;
    logic       addr_error;
  } result_t;

endpackage

// ===== sv/lgnc_ram.sv =====
// ----------------------------------------------------------------------------
// lgnc_ram: generic single write port ram with registered read
// bit write mask, one read address, read data valid the cycle after address
// ----------------------------------------------------------------------------
module lgnc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [WIDTH-1:0]         wmask,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/life_grid_neighbor_counter.sv =====
// ----------------------------------------------------------------------------
// life_grid_neighbor_counter: cell grid with live neighbor count
// set, clear and query of one-bit cells under three boundary modes
// ----------------------------------------------------------------------------
// usage
//   item channel: drive item with start high; the transfer happens at a rising
//   edge where start is high and busy is low. busy is low except in reset, so
//   one item can be taken every cycle.
//   result channel: every item gives one result, shown on result for exactly
//   one cycle with done high. an item taken is held in the stage-one register,
//   then its result is registered on result and transferred with done.
//   the receiver cannot stall; results are in item order.
//   the rate of one item per cycle is set by the grid ram: three copies, each
//   read at one row address per cycle (row above, own row, row below), and a
//   set makes the same write into all three.
//   configuration: wr_en, wr_index, wr_data write grid_rows, grid_cols and
//   boundary_mode; write only while no item is in flight.
//   reset: rst is synchronous, active high. config returns to a 64 by 64 grid
//   in classic mode; a per-row valid flag clears at once so the whole grid
//   reads dead without any clearing pass. clear works the same way.
// ----------------------------------------------------------------------------
module life_grid_neighbor_counter
  import lgnc_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   done,
  output result_t                result,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  // compare widths: hold both the size register and the maximum
  localparam int RSW = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
  localparam int CSW = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;
  localparam logic [RSW-1:0] ROWS_HI = RSW'(MAX_ROWS);
  localparam logic [CSW-1:0] COLS_HI = CSW'(MAX_COLS);

  // stage one: what the result stage needs besides the ram rows
  typedef struct packed {
    logic [1:0]    cmd;
    logic          err;
    logic          value;
    logic [CW-1:0] c_left;
    logic [CW-1:0] c_mid;
    logic [CW-1:0] c_right;
    logic          left_ok;
    logic          right_ok;
    logic          up_ok;
    logic          down_ok;
    logic [2:0]    row_vld;
  } stage_t;

  // configuration registers
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [1:0]        boundary_mode;

  logic [MAX_ROWS-1:0] row_valid;

  logic          accept;
  logic          is_donut;
  logic          is_mirror;
  logic [RSW-1:0] rows_use;
  logic [CSW-1:0] cols_use;
  logic [RSW-1:0] row_ext;
  logic [CSW-1:0] col_ext;
  logic          addr_err;
  logic [RW-1:0] r_idx;
  logic [RW-1:0] up_idx;
  logic [RW-1:0] dn_idx;
  logic          up_ok;
  logic          dn_ok;
  logic [CW-1:0] c_idx;
  logic [CW-1:0] lf_idx;
  logic [CW-1:0] rt_idx;
  logic          lf_ok;
  logic          rt_ok;
  logic [RW-1:0] rd_addr [3];

  logic                ram_we;
  logic [MAX_COLS-1:0] onehot;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [MAX_COLS-1:0] ram_wmask;
  logic [MAX_COLS-1:0] ram_q [3];

  logic    s1_valid;
  stage_t  s1;
  stage_t  s1_next;

  logic [7:0] nb_bits;
  logic [3:0] nb_count;
  result_t    result_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // configuration port, no read-back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= SIZE_W'(64);
      grid_cols     <= SIZE_W'(64);
      boundary_mode <= MODE_CLASSIC;
    end else if (wr_en) begin
      case (wr_index)
        REG_GRID_ROWS:     grid_rows     <= wr_data[SIZE_W-1:0];
        REG_GRID_COLS:     grid_cols     <= wr_data[SIZE_W-1:0];
        REG_BOUNDARY_MODE: boundary_mode <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // address stage: size in use, range check, neighbor rows and columns
  // ---------------------------------------------------------------------------
  always_comb begin
    // unknown mode behaves as classic
    case (boundary_mode)
      MODE_DONUT: begin
        is_donut  = 1'b1;
        is_mirror = 1'b0;
      end
      MODE_MIRROR: begin
        is_donut  = 1'b0;
        is_mirror = 1'b1;
      end
      default: begin
        is_donut  = 1'b0;
        is_mirror = 1'b0;
      end
    endcase

    // size registers saturate into 2..max
    if (RSW'(grid_rows) < RSW'(2))        rows_use = RSW'(2);
    else if (RSW'(grid_rows) > ROWS_HI)   rows_use = ROWS_HI;
    else                                  rows_use = RSW'(grid_rows);
    if (CSW'(grid_cols) < CSW'(2))        cols_use = CSW'(2);
    else if (CSW'(grid_cols) > COLS_HI)   cols_use = COLS_HI;
    else                                  cols_use = CSW'(grid_cols);

    row_ext  = RSW'(item.row);
    col_ext  = CSW'(item.col);
    addr_err = (row_ext >= rows_use) || (col_ext >= cols_use);
    r_idx    = row_ext[RW-1:0];
    c_idx    = col_ext[CW-1:0];

    // row above: wraps to the last row, mirrors onto row zero
    if (row_ext == '0) begin
      up_ok  = is_donut || is_mirror;
      up_idx = is_donut ? RW'(rows_use - RSW'(1)) : '0;
    end else begin
      up_ok  = 1'b1;
      up_idx = RW'(row_ext - RSW'(1));
    end

    // row below: wraps to row zero, mirrors onto the last row
    if (row_ext == rows_use - RSW'(1)) begin
      dn_ok  = is_donut || is_mirror;
      dn_idx = is_donut ? '0 : r_idx;
    end else begin
      dn_ok  = 1'b1;
      dn_idx = RW'(row_ext + RSW'(1));
    end

    if (col_ext == '0) begin
      lf_ok  = is_donut || is_mirror;
      lf_idx = is_donut ? CW'(cols_use - CSW'(1)) : '0;
    end else begin
      lf_ok  = 1'b1;
      lf_idx = CW'(col_ext - CSW'(1));
    end

    if (col_ext == cols_use - CSW'(1)) begin
      rt_ok  = is_donut || is_mirror;
      rt_idx = is_donut ? '0 : c_idx;
    end else begin
      rt_ok  = 1'b1;
      rt_idx = CW'(col_ext + CSW'(1));
    end

    rd_addr[0] = up_idx;
    rd_addr[1] = r_idx;
    rd_addr[2] = dn_idx;

    // set: one bit, or the whole row when it still holds stale data
    ram_we    = accept && (item.cmd == CMD_SET) && !addr_err;
    onehot    = MAX_COLS'(1) << c_idx;
    ram_wmask = row_valid[r_idx] ? onehot : '1;
    ram_wdata = item.cell_value ? onehot : '0;

    s1_next.cmd      = item.cmd;
    s1_next.err      = addr_err;
    s1_next.value    = item.cell_value;
    s1_next.c_left   = lf_idx;
    s1_next.c_mid    = c_idx;
    s1_next.c_right  = rt_idx;
    s1_next.left_ok  = lf_ok;
    s1_next.right_ok = rt_ok;
    s1_next.up_ok    = up_ok;
    s1_next.down_ok  = dn_ok;
    s1_next.row_vld  = {row_valid[dn_idx], row_valid[r_idx], row_valid[up_idx]};
  end

  // row valid flags: a cleared row reads dead until its next write
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (accept && item.cmd == CMD_CLEAR) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[r_idx] <= 1'b1;
    end
  end

  // three copies of the grid, one per neighbor row
  for (genvar k = 0; k < 3; k++) begin : g_grid
    lgnc_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (r_idx),
      .wdata (ram_wdata),
      .wmask (ram_wmask),
      .raddr (rd_addr[k]),
      .rdata (ram_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1 <= s1_next;
  end

  // ---------------------------------------------------------------------------
  // result stage: pick eight neighbor bits and count them
  // ---------------------------------------------------------------------------
  always_comb begin
    nb_bits[0] = ram_q[0][s1.c_left]  & s1.row_vld[0] & s1.up_ok   & s1.left_ok;
    nb_bits[1] = ram_q[0][s1.c_mid]   & s1.row_vld[0] & s1.up_ok;
    nb_bits[2] = ram_q[0][s1.c_right] & s1.row_vld[0] & s1.up_ok   & s1.right_ok;
    nb_bits[3] = ram_q[1][s1.c_left]  & s1.row_vld[1] & s1.left_ok;
    nb_bits[4] = ram_q[1][s1.c_right] & s1.row_vld[1] & s1.right_ok;
    nb_bits[5] = ram_q[2][s1.c_left]  & s1.row_vld[2] & s1.down_ok & s1.left_ok;
    nb_bits[6] = ram_q[2][s1.c_mid]   & s1.row_vld[2] & s1.down_ok;
    nb_bits[7] = ram_q[2][s1.c_right] & s1.row_vld[2] & s1.down_ok & s1.right_ok;

    nb_count = '0;
    for (int i = 0; i < 8; i++) begin
      nb_count = nb_count + 4'(nb_bits[i]);
    end

    result_next = '0;
    case (s1.cmd)
      CMD_SET: begin
        if (s1.err) begin
          result_next.addr_error = 1'b1;
        end else begin
          result_next.cell_alive = s1.value;
        end
      end
      CMD_QUERY: begin
        if (s1.err) begin
          result_next.addr_error = 1'b1;
        end else begin
          result_next.cell_alive     = ram_q[1][s1.c_mid] & s1.row_vld[1];
          result_next.neighbor_count = nb_count;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    result <= result_next;
  end

`ifndef SYNTH
  // every transfer in gives exactly one result, via the stage-one and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, 2))
    else $error("result strobe does not follow item transfer");

  // an error result carries no cell state
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.addr_error |-> !result.cell_alive && result.neighbor_count == 4'd0)
    else $error("error result with nonzero fields");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.neighbor_count <= 4'd8)
    else $error("neighbor count above eight");

  // clear drops every row at once
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item.cmd == CMD_CLEAR |=> row_valid == '0)
    else $error("rows still valid after clear");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for life_grid_neighbor_counter
// a shadow grid predicts every result from the items as they transfer; a
// monitor compares each strobed result with the oldest prediction; the grid
// size and edge handling are changed between phases while the block is idle
// ----------------------------------------------------------------------------
module tb
  import lgnc_pkg::*;
();

  localparam int GRID_MAX_ROWS = 64;
  localparam int GRID_MAX_COLS = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, all known from time zero
  logic                   start    = 1'b0;
  item_t                  item     = '0;
  logic                   wr_en    = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data  = '0;

  logic    busy;
  logic    done;
  result_t result;

  life_grid_neighbor_counter dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // shadow copy of the block: grid contents and register values
  // --------------------------------------------------------------------------
  logic [GRID_MAX_COLS-1:0] shadow_grid [GRID_MAX_ROWS];
  logic [SIZE_W-1:0]        shadow_rows = 7'd64;
  logic [SIZE_W-1:0]        shadow_cols = 7'd64;
  logic [1:0]               shadow_mode = MODE_CLASSIC;

  item_t   pending_items[$];     // items waiting for the driver
  result_t expected_results[$];  // predictions waiting for their strobe

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int win_row        = 0;        // per-phase focus window so cells cluster
  int win_col        = 0;

  initial begin
    for (int r = 0; r < GRID_MAX_ROWS; r++) shadow_grid[r] = '0;
  end

  // size registers saturate to 2..max
  function automatic int rows_in_use();
    if (shadow_rows < 2) return 2;
    if (shadow_rows > GRID_MAX_ROWS) return GRID_MAX_ROWS;
    return int'(shadow_rows);
  endfunction

  function automatic int cols_in_use();
    if (shadow_cols < 2) return 2;
    if (shadow_cols > GRID_MAX_COLS) return GRID_MAX_COLS;
    return int'(shadow_cols);
  endfunction

  // applies one item to the shadow grid and returns the result it causes
  function automatic result_t apply_grid_item(item_t it);
    result_t res;
    int      rows;
    int      cols;
    int      r;
    int      c;
    int      nr;
    int      nc;
    logic [3:0] live;
    res  = '0;
    rows = rows_in_use();
    cols = cols_in_use();
    r    = int'(it.row);
    c    = int'(it.col);
    if (it.cmd == CMD_CLEAR) begin
      // every stored cell dies, also those outside the size in use
      for (int i = 0; i < GRID_MAX_ROWS; i++) shadow_grid[i] = '0;
      return res;
    end
    if (it.cmd == CMD_UNKNOWN) return res;
    if (r >= rows || c >= cols) begin
      res.addr_error = 1'b1;
      return res;
    end
    if (it.cmd == CMD_SET) begin
      shadow_grid[r][c] = it.cell_value;
      res.cell_alive = it.cell_value;
      return res;
    end
    // query: walk the eight positions around the cell
    live = '0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        nr = r + dr;
        nc = c + dc;
        if (shadow_mode == MODE_DONUT) begin
          if (nr < 0) nr = rows - 1;
          if (nr >= rows) nr = 0;
          if (nc < 0) nc = cols - 1;
          if (nc >= cols) nc = 0;
        end else if (shadow_mode == MODE_MIRROR) begin
          // clamp onto the edge, so an edge cell may count itself
          if (nr < 0) nr = 0;
          if (nr >= rows) nr = rows - 1;
          if (nc < 0) nc = 0;
          if (nc >= cols) nc = cols - 1;
        end else begin
          // classic and the unknown mode: past the edge is dead
          if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        end
        live = live + 4'(shadow_grid[nr][nc]);
      end
    end
    res.cell_alive     = shadow_grid[r][c];
    res.neighbor_count = live;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t make_item(logic [1:0] cmd, int row, int col, logic val);
    item_t it;
    it.cmd        = cmd;
    it.row        = 6'(row);
    it.col        = 6'(col);
    it.cell_value = val;
    return it;
  endfunction

  // one coordinate: mostly in use and near the focus window or the edges,
  // sometimes anywhere in 0..63 so out-of-range addresses and all bits show up
  function automatic int pick_coord(int size, int win);
    int q;
    int sel;
    q = $urandom_range(0, 99);
    if (q < 12) return $urandom_range(0, 63);
    if (q < 40) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: return 0;
        1: return 1;
        2: return size - 2;
        default: return size - 1;
      endcase
    end
    if (size <= 8) return $urandom_range(0, size - 1);
    return win + $urandom_range(0, 7);
  endfunction

  function automatic item_t random_grid_item();
    int   p;
    logic [1:0] cmd;
    logic val;
    p = $urandom_range(0, 99);
    if (p < 2) cmd = CMD_CLEAR;
    else if (p < 5) cmd = CMD_UNKNOWN;
    else if (p < 45) cmd = CMD_SET;
    else cmd = CMD_QUERY;
    // sets lean toward alive so queries see crowded neighborhoods
    if (cmd == CMD_SET) val = ($urandom_range(0, 99) < 65);
    else val = 1'($urandom_range(0, 1));
    return make_item(cmd, pick_coord(rows_in_use(), win_row),
                     pick_coord(cols_in_use(), win_col), val);
  endfunction

  // waits until no item is queued or in flight, plus a short margin
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      REG_GRID_ROWS:     shadow_rows = data;
      REG_GRID_COLS:     shadow_cols = data;
      REG_BOUNDARY_MODE: shadow_mode = data[1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // new grid setting, only once the block has gone quiet
  task automatic set_config(int rows, int cols, logic [1:0] mode);
    wait_drained();
    write_reg(REG_GRID_ROWS, 7'(rows));
    write_reg(REG_GRID_COLS, 7'(cols));
    write_reg(REG_BOUNDARY_MODE, 7'(mode));
    win_row = (rows_in_use() > 8) ? $urandom_range(0, rows_in_use() - 8) : 0;
    win_col = (cols_in_use() > 8) ? $urandom_range(0, cols_in_use() - 8) : 0;
  endtask

  task automatic queue_random_items(int count);
    @(negedge clk);
    repeat (count) pending_items.push_back(random_grid_item());
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps, fed from pending_items
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // transfer at this edge: predict and retire the head
        expected_results.push_back(apply_grid_item(item));
        void'(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        start <= 1'b1;
        item  <= pending_items[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // next burst; a quarter of them run back to back with no gap
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: one strobe, one result, compared field by field in order
  // --------------------------------------------------------------------------
  result_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("tb: mismatch: result with nothing expected: alive %0b count %0d err %0b",
                   result.cell_alive, result.neighbor_count, result.addr_error);
      end else begin
        want = expected_results.pop_front();
        if (result.cell_alive !== want.cell_alive ||
            result.neighbor_count !== want.neighbor_count ||
            result.addr_error !== want.addr_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: mismatch: expected alive %0b count %0d err %0b,",
                     want.cell_alive, want.neighbor_count, want.addr_error,
                     " got alive %0b count %0d err %0b",
                     result.cell_alive, result.neighbor_count, result.addr_error);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transfer on either side ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset setting, 64 by 64 classic: far corners, unknown command, clear
    @(negedge clk);
    pending_items.push_back(make_item(CMD_SET, 0, 0, 1'b1));
    pending_items.push_back(make_item(CMD_SET, 0, 1, 1'b1));
    pending_items.push_back(make_item(CMD_SET, 63, 63, 1'b1));
    pending_items.push_back(make_item(CMD_SET, 62, 63, 1'b1));
    pending_items.push_back(make_item(CMD_QUERY, 0, 0, 1'b0));
    pending_items.push_back(make_item(CMD_QUERY, 63, 62, 1'b1));
    pending_items.push_back(make_item(CMD_UNKNOWN, 63, 63, 1'b1));
    pending_items.push_back(make_item(CMD_CLEAR, 63, 63, 1'b1));
    pending_items.push_back(make_item(CMD_QUERY, 0, 0, 1'b0));
    pending_items.push_back(make_item(CMD_SET, 0, 0, 1'b0));

    // sizes below range saturate to a 2 by 2 donut: positions repeat
    set_config(1, 0, MODE_DONUT);
    @(negedge clk);
    pending_items.push_back(make_item(CMD_SET, 0, 0, 1'b1));
    pending_items.push_back(make_item(CMD_SET, 1, 1, 1'b1));
    pending_items.push_back(make_item(CMD_QUERY, 0, 1, 1'b0));
    pending_items.push_back(make_item(CMD_QUERY, 1, 0, 1'b0));
    pending_items.push_back(make_item(CMD_QUERY, 2, 0, 1'b0));
    pending_items.push_back(make_item(CMD_SET, 0, 63, 1'b1));
    pending_items.push_back(make_item(CMD_QUERY, 63, 63, 1'b1));

    // rows above range saturate to 64; mirror lets a corner count itself
    set_config(127, 3, MODE_MIRROR);
    @(negedge clk);
    pending_items.push_back(make_item(CMD_SET, 63, 0, 1'b1));
    pending_items.push_back(make_item(CMD_QUERY, 63, 0, 1'b0));
    pending_items.push_back(make_item(CMD_QUERY, 63, 2, 1'b0));
    pending_items.push_back(make_item(CMD_SET, 0, 2, 1'b1));
    pending_items.push_back(make_item(CMD_QUERY, 0, 2, 1'b0));

    // unknown edge mode behaves as classic
    set_config(64, 64, MODE_UNKNOWN);
    @(negedge clk);
    pending_items.push_back(make_item(CMD_QUERY, 63, 0, 1'b0));
    pending_items.push_back(make_item(CMD_QUERY, 62, 1, 1'b0));

    // random phases over the extremes and some random settings
    set_config(64, 64, MODE_CLASSIC);
    queue_random_items(120);
    set_config(64, 64, MODE_DONUT);
    queue_random_items(100);
    set_config(64, 64, MODE_MIRROR);
    queue_random_items(100);
    set_config(2, 2, MODE_DONUT);
    queue_random_items(80);
    set_config(2, 2, MODE_MIRROR);
    queue_random_items(80);
    set_config(3, 5, MODE_CLASSIC);
    queue_random_items(80);
    set_config(2, 64, MODE_DONUT);
    queue_random_items(80);
    set_config(64, 2, MODE_MIRROR);
    queue_random_items(80);
    set_config(0, 127, MODE_UNKNOWN);
    queue_random_items(80);
    set_config(1, 65, MODE_DONUT);
    queue_random_items(80);
    repeat (4) begin
      set_config($urandom_range(0, 127), $urandom_range(0, 127), 2'($urandom_range(0, 3)));
      queue_random_items(60);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
